### hw/rtl/red_queue_admission_unit_macros.svh
// assertion macros shared by the red queue admission rtl
// no dependencies; included by the modules that carry assertions
`ifndef RED_QUEUE_ADMISSION_UNIT_MACROS_SVH
`define RED_QUEUE_ADMISSION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define RQA_ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rqa assertion failed");
// property checked on every rising edge, reset included
`define RQA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rqa assertion failed");
`else
`define RQA_ASSERT_AT(lbl, clk, rstn, prop)
`define RQA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hw/rtl/rqa_pkg.sv
// types and constants of the red queue admission unit
// no dependencies; used by rqa_alu and red_queue_admission_unit
package rqa_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int OCC_BITS      = 24;
  localparam int TIME_BITS     = 32;
  localparam int IDLE_EXP_BITS = 16;
  localparam int AVG_BITS      = OCC_BITS + FRAC_BITS;
  localparam int OPA_W         = 40;
  localparam int OPB_W         = 32;
  localparam int PROD_W        = OPA_W + OPB_W;
  localparam int STEP_W        = 6;

  localparam logic [16:0] Q_ONE     = 17'h10000;
  localparam logic [16:0] COUNT_MAX = 17'h0FFFF;

  // verdict codes
  localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
  localparam logic [2:0] VERDICT_FULL   = 3'd1;
  localparam logic [2:0] VERDICT_EARLY  = 3'd2;
  localparam logic [2:0] VERDICT_FORCED = 3'd3;
  localparam logic [2:0] VERDICT_DEPART = 3'd4;
  localparam logic [2:0] VERDICT_EMPTY  = 3'd5;

  // register indexes
  localparam logic [2:0] REG_AVG_WEIGHT = 3'd0;
  localparam logic [2:0] REG_MIN_TH     = 3'd1;
  localparam logic [2:0] REG_MAX_TH     = 3'd2;
  localparam logic [2:0] REG_LIMIT      = 3'd3;
  localparam logic [2:0] REG_MAX_PROB   = 3'd4;
  localparam logic [2:0] REG_IDLE_RATE  = 3'd5;

  typedef struct packed {
    logic              start;
    logic              op_div;
    logic [OPA_W-1:0]  opa;    // multiplicand or divisor
    logic [OPB_W-1:0]  opb;    // multiplier or dividend
    logic [OPA_W-1:0]  rem0;   // initial remainder for division
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] prod;
    logic [OPB_W-1:0]  quo;
  } alu_rsp_t;

endpackage

### hw/rtl/rqa_alu.sv
// shared bit-serial multiply / restoring divide unit, one bit per cycle
// depends on rqa_pkg
module rqa_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rqa_pkg::alu_req_t req_i,
  output rqa_pkg::alu_rsp_t rsp_o
);

  logic                              busy_q, done_q, div_q;
  logic [rqa_pkg::STEP_W-1:0]        cnt_q;
  logic [rqa_pkg::OPA_W-1:0]         a_q;
  logic [rqa_pkg::OPB_W-1:0]         b_q, b_d;
  logic [rqa_pkg::PROD_W-1:0]        acc_q, acc_d;
  logic [rqa_pkg::OPA_W:0]           trial, diff;
  logic                              ge;

  always_comb begin
    trial = {acc_q[rqa_pkg::OPA_W-1:0], b_q[rqa_pkg::OPB_W-1]};
    ge    = trial >= {1'b0, a_q};
    diff  = trial - {1'b0, a_q};
    if (div_q) begin
      acc_d = {{rqa_pkg::OPB_W{1'b0}},
               (ge ? diff[rqa_pkg::OPA_W-1:0] : trial[rqa_pkg::OPA_W-1:0])};
      b_d   = {b_q[rqa_pkg::OPB_W-2:0], ge};
    end else begin
      // msb-first shift and add
      acc_d = {acc_q[rqa_pkg::PROD_W-2:0], 1'b0}
            + (b_q[rqa_pkg::OPB_W-1] ? {{rqa_pkg::OPB_W{1'b0}}, a_q}
                                     : {rqa_pkg::PROD_W{1'b0}});
      b_d   = {b_q[rqa_pkg::OPB_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - rqa_pkg::STEP_W'(1);
      if (cnt_q == rqa_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.op_div;
      a_q   <= req_i.opa;
      // left-align the operand so its top bit is consumed first
      b_q   <= req_i.opb << (rqa_pkg::STEP_W'(rqa_pkg::OPB_W) - req_i.steps);
      acc_q <= req_i.op_div ? {{rqa_pkg::OPB_W{1'b0}}, req_i.rem0}
                            : {rqa_pkg::PROD_W{1'b0}};
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
  assign rsp_o.quo  = b_q;

endmodule

### hw/rtl/red_queue_admission_unit.sv
// red admission control on rqa_alu, rqa_pkg and the macros header: one request, one verdict
// a departure is answered straight from the occupancy; an arrival updates the average and,
//   between the thresholds, runs the early drop test, cut short when its probability saturates;
//   an arrival into an empty queue first decays the average by squarings and decay multiplies
// one request in flight: the next is taken after its verdict is loaded into the output register
// reset (async, active low): state cleared, drop count minus one, registers at defaults
`include "red_queue_admission_unit_macros.svh"
module red_queue_admission_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // packet_size[15:0], time_now[47:16], random_value[63:48]
  input  logic        s_axis_tuser,   // kind
  // verdict stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // occupancy_bytes[23:0], average_bytes[47:24]
  output logic [2:0]  m_axis_tuser,   // verdict
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEP   = 5'd1;
  localparam logic [4:0] S_ARR   = 5'd2;
  localparam logic [4:0] S_RATE  = 5'd3;
  localparam logic [4:0] S_DLOOP = 5'd4;
  localparam logic [4:0] S_SQR   = 5'd5;
  localparam logic [4:0] S_DBIT  = 5'd6;
  localparam logic [4:0] S_FMUL  = 5'd7;
  localparam logic [4:0] S_DNXT  = 5'd8;
  localparam logic [4:0] S_SCALE = 5'd9;
  localparam logic [4:0] S_EWMA  = 5'd10;
  localparam logic [4:0] S_JUDGE = 5'd11;
  localparam logic [4:0] S_FRAC  = 5'd12;
  localparam logic [4:0] S_PB    = 5'd13;
  localparam logic [4:0] S_PROD  = 5'd14;
  localparam logic [4:0] S_PA    = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  localparam int AW = rqa_pkg::AVG_BITS;
  localparam int OW = rqa_pkg::OCC_BITS;
  localparam int FB = rqa_pkg::FRAC_BITS;

  // configuration registers
  logic [15:0] w_q, maxp_q;
  logic [OW-1:0] minth_q, maxth_q, limit_q;
  logic [31:0] rate_q;

  // queue state
  logic [4:0]    state_q, state_d;
  logic [OW-1:0] occ_q, occ_d;
  logic [AW-1:0] avg_q, avg_d;
  logic [16:0]   cnt_q, cnt_d;
  logic [rqa_pkg::TIME_BITS-1:0] idle_q, idle_d;

  // request being worked on
  logic [15:0] size_q, rnd_q;
  logic [rqa_pkg::TIME_BITS-1:0] now_q;

  // working registers
  logic [OW-1:0] occn_q, occn_d;
  logic          up_q, up_d;
  logic [rqa_pkg::IDLE_EXP_BITS-1:0] m_q, m_d;
  logic [16:0]   r_q, r_d;
  logic [3:0]    bit_q, bit_d;
  logic [15:0]   pb_q, pb_d;
  logic [2:0]    res_q, res_d;

  // output register
  logic          ovalid_q;
  logic [2:0]    overd_q;
  logic [OW-1:0] oocc_q, oavg_q;

  rqa_pkg::alu_req_t alu_req;
  rqa_pkg::alu_rsp_t alu_rsp;

  logic          accept, cfg_wr;
  logic [AW-1:0] lo40, hi40;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == S_IDLE;
  assign lo40 = {minth_q, {FB{1'b0}}};
  assign hi40 = {maxth_q, {FB{1'b0}}};

  rqa_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // main sequencer
  always_comb begin
    logic [OW:0]   occ_sum;
    logic [AW-1:0] target, q40;
    logic [32:0]   pa_wide;
    logic [16:0]   pa;
    logic [rqa_pkg::TIME_BITS-1:0] elapsed;

    state_d = state_q;
    occ_d   = occ_q;
    avg_d   = avg_q;
    cnt_d   = cnt_q;
    idle_d  = idle_q;
    occn_d  = occn_q;
    up_d    = up_q;
    m_d     = m_q;
    r_d     = r_q;
    bit_d   = bit_q;
    pb_d    = pb_q;
    res_d   = res_q;
    alu_req = '0;

    occ_sum = {1'b0, occ_q} + {{(OW + 1 - 16){1'b0}}, size_q};
    target  = {occn_q, {FB{1'b0}}};
    q40     = alu_rsp.prod[AW+FB-1:FB];
    elapsed = now_q - idle_q;
    pa_wide = {1'b0, alu_rsp.quo};
    pa      = (pa_wide > {16'd0, rqa_pkg::Q_ONE}) ? rqa_pkg::Q_ONE : pa_wide[16:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = s_axis_tuser ? S_DEP : S_ARR;
        end
      end
      S_DEP: begin
        if (occ_q == '0) begin
          idle_d = now_q;
          res_d  = rqa_pkg::VERDICT_EMPTY;
        end else begin
          if ({{(OW - 16){1'b0}}, size_q} >= occ_q) begin
            occ_d  = '0;
            idle_d = now_q;
          end else begin
            occ_d = occ_q - {{(OW - 16){1'b0}}, size_q};
          end
          res_d = rqa_pkg::VERDICT_DEPART;
        end
        state_d = S_DONE;
      end
      S_ARR: begin
        if (occ_q == '0) begin
          // idle count m = elapsed * rate / 2^16
          alu_req.start = 1'b1;
          alu_req.opa   = {8'd0, elapsed};
          alu_req.opb   = rate_q;
          alu_req.steps = rqa_pkg::STEP_W'(32);
          state_d = S_RATE;
        end else begin
          occn_d = occ_sum[OW] ? {OW{1'b1}} : occ_sum[OW-1:0];
          state_d = S_EWMA;
          alu_req.start = 1'b1;
          // magnitude of the distance to the new occupancy times the weight
          if ({occn_d, {FB{1'b0}}} >= avg_q) begin
            up_d        = 1'b1;
            alu_req.opa = {occn_d, {FB{1'b0}}} - avg_q;
          end else begin
            up_d        = 1'b0;
            alu_req.opa = avg_q - {occn_d, {FB{1'b0}}};
          end
          alu_req.opb   = {16'd0, w_q};
          alu_req.steps = rqa_pkg::STEP_W'(16);
        end
      end
      S_RATE: begin
        if (alu_rsp.done) begin
          m_d     = (alu_rsp.prod[63:32] != '0) ? '1 : alu_rsp.prod[31:16];
          r_d     = rqa_pkg::Q_ONE;
          bit_d   = 4'd15;
          state_d = S_DLOOP;
        end
      end
      S_DLOOP: begin
        // squaring one is one, so that step is skipped
        if (r_q != rqa_pkg::Q_ONE) begin
          alu_req.start = 1'b1;
          alu_req.opa   = {23'd0, r_q};
          alu_req.opb   = {15'd0, r_q};
          alu_req.steps = rqa_pkg::STEP_W'(17);
          state_d = S_SQR;
        end else begin
          state_d = S_DBIT;
        end
      end
      S_SQR: begin
        if (alu_rsp.done) begin
          r_d     = alu_rsp.prod[32:16];
          state_d = S_DBIT;
        end
      end
      S_DBIT: begin
        if (m_q[bit_q]) begin
          alu_req.start = 1'b1;
          alu_req.opa   = {23'd0, r_q};
          alu_req.opb   = {15'd0, rqa_pkg::Q_ONE - {1'b0, w_q}};
          alu_req.steps = rqa_pkg::STEP_W'(17);
          state_d = S_FMUL;
        end else begin
          state_d = S_DNXT;
        end
      end
      S_FMUL: begin
        if (alu_rsp.done) begin
          r_d     = alu_rsp.prod[32:16];
          state_d = S_DNXT;
        end
      end
      S_DNXT: begin
        if (bit_q == 4'd0) begin
          alu_req.start = 1'b1;
          alu_req.opa   = avg_q;
          alu_req.opb   = {15'd0, r_q};
          alu_req.steps = rqa_pkg::STEP_W'(17);
          state_d = S_SCALE;
        end else begin
          bit_d   = bit_q - 4'd1;
          state_d = S_DLOOP;
        end
      end
      S_SCALE: begin
        if (alu_rsp.done) begin
          avg_d   = q40;
          occ_d   = {{(OW - 16){1'b0}}, size_q};
          res_d   = rqa_pkg::VERDICT_ACCEPT;
          state_d = S_DONE;
        end
      end
      S_EWMA: begin
        if (alu_rsp.done) begin
          if (up_q) begin
            avg_d = avg_q + q40;
          end else begin
            avg_d = avg_q - q40 - {{(AW - 1){1'b0}}, (alu_rsp.prod[FB-1:0] != '0)};
          end
          state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        state_d = S_DONE;
        if (occn_q > limit_q) begin
          cnt_d = '0;
          res_d = rqa_pkg::VERDICT_FULL;
        end else if (avg_q >= lo40 && avg_q < hi40) begin
          if (cnt_q != rqa_pkg::COUNT_MAX) begin
            cnt_d = cnt_q + 17'd1;
          end
          // frac = (avg - min) / (max - min), 16 quotient bits
          alu_req.start  = 1'b1;
          alu_req.op_div = 1'b1;
          alu_req.opa    = hi40 - lo40;
          alu_req.rem0   = avg_q - lo40;
          alu_req.steps  = rqa_pkg::STEP_W'(16);
          state_d = S_FRAC;
        end else if (avg_q >= hi40) begin
          cnt_d = '0;
          res_d = rqa_pkg::VERDICT_FORCED;
        end else begin
          occ_d = occn_q;
          cnt_d = '1;
          res_d = rqa_pkg::VERDICT_ACCEPT;
        end
      end
      S_FRAC: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.opa   = {24'd0, maxp_q};
          alu_req.opb   = {16'd0, alu_rsp.quo[15:0]};
          alu_req.steps = rqa_pkg::STEP_W'(16);
          state_d = S_PB;
        end
      end
      S_PB: begin
        if (alu_rsp.done) begin
          pb_d = alu_rsp.prod[31:16];
          alu_req.start = 1'b1;
          alu_req.opa   = {24'd0, cnt_q[15:0]};
          alu_req.opb   = {16'd0, alu_rsp.prod[31:16]};
          alu_req.steps = rqa_pkg::STEP_W'(16);
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        if (alu_rsp.done) begin
          if (alu_rsp.prod[31:16] != '0) begin
            // probability saturates at one: always an early drop
            cnt_d   = '0;
            res_d   = rqa_pkg::VERDICT_EARLY;
            state_d = S_DONE;
          end else begin
            alu_req.start  = 1'b1;
            alu_req.op_div = 1'b1;
            alu_req.opa    = {23'd0, rqa_pkg::Q_ONE - {1'b0, alu_rsp.prod[15:0]}};
            alu_req.opb    = {pb_q, 16'd0};
            alu_req.steps  = rqa_pkg::STEP_W'(32);
            state_d = S_PA;
          end
        end
      end
      S_PA: begin
        if (alu_rsp.done) begin
          if ({1'b0, rnd_q} <= pa) begin
            cnt_d = '0;
            res_d = rqa_pkg::VERDICT_EARLY;
          end else begin
            occ_d = occn_q;
            res_d = rqa_pkg::VERDICT_ACCEPT;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!ovalid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      avg_q    <= '0;
      cnt_q    <= '1;
      idle_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      avg_q   <= avg_d;
      cnt_q   <= cnt_d;
      idle_q  <= idle_d;
      if (state_q == S_DONE && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q <= s_axis_tdata[15:0];
      now_q  <= s_axis_tdata[47:16];
      rnd_q  <= s_axis_tdata[63:48];
    end
    occn_q <= occn_d;
    up_q   <= up_d;
    m_q    <= m_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    pb_q   <= pb_d;
    res_q  <= res_d;
    if (state_q == S_DONE && (!ovalid_q || m_axis_tready)) begin
      overd_q <= res_q;
      oocc_q  <= occ_q;
      oavg_q  <= avg_q[AW-1:FB];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oavg_q, oocc_q};
  assign m_axis_tuser  = overd_q;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= 16'd131;
      minth_q <= OW'(2500);
      maxth_q <= OW'(7500);
      limit_q <= OW'(30000);
      maxp_q  <= 16'd6554;
      rate_q  <= 32'd105;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        rqa_pkg::REG_AVG_WEIGHT: w_q     <= pwdata[15:0];
        rqa_pkg::REG_MIN_TH:     minth_q <= pwdata[OW-1:0];
        rqa_pkg::REG_MAX_TH:     maxth_q <= pwdata[OW-1:0];
        rqa_pkg::REG_LIMIT:      limit_q <= pwdata[OW-1:0];
        rqa_pkg::REG_MAX_PROB:   maxp_q  <= pwdata[15:0];
        rqa_pkg::REG_IDLE_RATE:  rate_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rqa_pkg::REG_AVG_WEIGHT: prdata = {16'd0, w_q};
      rqa_pkg::REG_MIN_TH:     prdata = {8'd0, minth_q};
      rqa_pkg::REG_MAX_TH:     prdata = {8'd0, maxth_q};
      rqa_pkg::REG_LIMIT:      prdata = {8'd0, limit_q};
      rqa_pkg::REG_MAX_PROB:   prdata = {16'd0, maxp_q};
      rqa_pkg::REG_IDLE_RATE:  prdata = rate_q;
      default:                 prdata = 32'd0;
    endcase
  end

  // the alu is never restarted while a step sequence runs
  `RQA_ASSERT_AT(a_alu_no_overlap, clk_i, rst_ni, alu_req.start |-> !alu_rsp.busy)
  // an accepted request always leaves the idle state
  `RQA_ASSERT_AT(a_req_leaves_idle, clk_i, rst_ni, accept |=> state_q != S_IDLE)
  // drop count stays within minus one to its saturation value
  `RQA_ASSERT_ALWAYS(a_cnt_range, clk_i, !rst_ni || !cnt_q[16] || cnt_q == 17'h1FFFF)

endmodule
